// ===== rtl/pbs_pkg.sv =====
// Package: shared types and codes for the protobuf status message parser.
`default_nettype none
package pbs_pkg;

	localparam int LEN_W = 6;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_KEY_BAD  = 3'd1;
	localparam logic [2:0] ST_OKV_BAD  = 3'd2;
	localparam logic [2:0] ST_LEN_BAD  = 3'd3;
	localparam logic [2:0] ST_LEN_PAST = 3'd4;
	localparam logic [2:0] ST_F32_BAD  = 3'd5;
	localparam logic [2:0] ST_WT_BAD   = 3'd6;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_F64    = 3'd1;
	localparam logic [2:0] WT_LEN    = 3'd2;
	localparam logic [2:0] WT_F32    = 3'd5;

	localparam logic [31:0] FIELD_OK   = 32'd1;
	localparam logic [31:0] FIELD_TEXT = 32'd2;

	typedef enum logic [5:0] {
		PH_KEY     = 6'b000001,
		PH_OKVAL   = 6'b000010,
		PH_LEN     = 6'b000100,
		PH_BODY    = 6'b001000,
		PH_SKIPVAR = 6'b010000,
		PH_FIX     = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_TEXT    = 3'd1,
		ACT_SKIPLEN = 3'd2,
		ACT_F64     = 3'd3,
		ACT_F32     = 3'd4
	} action_t;

	typedef struct packed {
		logic take;
		logic clear;
		logic load_sum;
		logic load_text;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic text_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/pbs_ctrl.sv =====
// Controller: request acceptance and result sequencing state machine.
`default_nettype none
module pbs_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            msg_valid,
	output logic           msg_stall,
	input  wire            is_last,
	input  wire            no_byte,
	input  pbs_pkg::sts_t  sts,
	output pbs_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_RUN  = 3'b001,
		S_SUM  = 3'b010,
		S_TEXT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign msg_stall = (state_q != S_RUN);
	assign accept    = msg_valid && !msg_stall;

	always_comb begin
		state_d       = state_q;
		cmd.take      = 1'b0;
		cmd.clear     = 1'b0;
		cmd.load_sum  = 1'b0;
		cmd.load_text = 1'b0;
		case (state_q)
			S_RUN: begin
				cmd.take = accept && !no_byte;
				if (accept && is_last) begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				if (sts.out_free) begin
					cmd.load_sum = 1'b1;
					if (sts.len_zero) begin
						cmd.clear = 1'b1;
						state_d   = S_RUN;
					end else begin
						state_d = S_TEXT;
					end
				end
			end
			S_TEXT: begin
				if (sts.out_free) begin
					cmd.load_text = 1'b1;
					if (sts.text_last) begin
						cmd.clear = 1'b1;
						state_d   = S_RUN;
					end
				end
			end
			default: begin
				state_d = S_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pbs_dp.sv =====
// Datapath: wire format parse state, two-bank text store and result register.
`default_nettype none
module pbs_dp #(
	parameter int ERR_CAP = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  pbs_pkg::cmd_t                cmd,
	output pbs_pkg::sts_t                sts,
	input  wire  [7:0]                   data_byte,
	output logic                         res_valid,
	input  wire                          res_stall,
	output logic                         kind,
	output logic [2:0]                   status,
	output logic                         ok_flag,
	output logic [pbs_pkg::LEN_W-1:0]    error_length,
	output logic [7:0]                   error_char,
	output logic                         last_result
);

	localparam int IDX_W = $clog2(ERR_CAP);
	localparam int MEM_D = 2 * (2 ** IDX_W);
	localparam int LW    = pbs_pkg::LEN_W;
	localparam logic [LW-1:0] TEXT_MAX = LW'(ERR_CAP - 1);

	pbs_pkg::phase_t  phase_q;
	pbs_pkg::action_t action_q;
	logic [63:0]      accum_q;
	logic [3:0]       cnt_q;
	logic [63:0]      rem_q;
	logic             ok_q;
	logic [2:0]       err_q;
	logic             bank_q;
	logic [LW-1:0]    clen_q;
	logic [LW-1:0]    plen_q;
	logic [LW-1:0]    tk_q;

	logic [7:0]       mem [MEM_D];
	logic [7:0]       rdata_q;

	logic [5:0]       shamt;
	logic [63:0]      acc_next;
	logic             v_done;
	logic             v_long;
	logic [31:0]      field;
	logic [2:0]       wt;
	logic [63:0]      rem_dec;
	logic [LW-1:0]    plen_inc;
	logic             wr_en;
	logic [LW-1:0]    rd_idx;
	logic [LW-1:0]    tk_inc;
	logic [2:0]       end_st;
	logic             step;

	pbs_pkg::phase_t  phase_d;
	pbs_pkg::action_t action_d;
	logic [63:0]      accum_d;
	logic [3:0]       cnt_d;
	logic [63:0]      rem_d;
	logic             ok_d;
	logic [2:0]       err_d;
	logic             bank_d;
	logic [LW-1:0]    clen_d;
	logic [LW-1:0]    plen_d;

	assign step     = cmd.take && (err_q == pbs_pkg::ST_OK);
	assign shamt    = {2'b00, cnt_q} * 6'd7;
	assign acc_next = accum_q | (64'(data_byte[6:0]) << shamt);
	assign v_done   = !data_byte[7];
	assign v_long   = data_byte[7] && (cnt_q == 4'd9);
	assign field    = acc_next[34:3];
	assign wt       = acc_next[2:0];
	assign rem_dec  = rem_q - 64'd1;
	assign plen_inc = plen_q + LW'(1);
	assign tk_inc   = tk_q + LW'(1);
	assign rd_idx   = cmd.load_text ? tk_inc : tk_q;

	always_comb begin
		phase_d  = phase_q;
		action_d = action_q;
		accum_d  = accum_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		ok_d     = ok_q;
		err_d    = err_q;
		bank_d   = bank_q;
		clen_d   = clen_q;
		plen_d   = plen_q;
		wr_en    = 1'b0;
		if (step && (phase_q != pbs_pkg::PH_BODY) && (phase_q != pbs_pkg::PH_FIX)) begin
			accum_d = v_done ? 64'd0 : acc_next;
			cnt_d   = (v_done || v_long) ? 4'd0 : cnt_q + 4'd1;
		end
		if (step) begin
			case (phase_q)
				pbs_pkg::PH_KEY: begin
					if (v_long) begin
						err_d = pbs_pkg::ST_KEY_BAD;
					end else if (v_done) begin
						if (field == pbs_pkg::FIELD_OK && wt == pbs_pkg::WT_VARINT) begin
							phase_d = pbs_pkg::PH_OKVAL;
						end else if (field == pbs_pkg::FIELD_TEXT && wt == pbs_pkg::WT_LEN) begin
							phase_d  = pbs_pkg::PH_LEN;
							action_d = pbs_pkg::ACT_TEXT;
						end else if (wt == pbs_pkg::WT_VARINT) begin
							phase_d = pbs_pkg::PH_SKIPVAR;
						end else if (wt == pbs_pkg::WT_F64) begin
							phase_d  = pbs_pkg::PH_FIX;
							action_d = pbs_pkg::ACT_F64;
							rem_d    = 64'd8;
						end else if (wt == pbs_pkg::WT_LEN) begin
							phase_d  = pbs_pkg::PH_LEN;
							action_d = pbs_pkg::ACT_SKIPLEN;
						end else if (wt == pbs_pkg::WT_F32) begin
							phase_d  = pbs_pkg::PH_FIX;
							action_d = pbs_pkg::ACT_F32;
							rem_d    = 64'd4;
						end else begin
							err_d = pbs_pkg::ST_WT_BAD;
						end
					end
				end
				pbs_pkg::PH_OKVAL: begin
					if (v_long) begin
						err_d = pbs_pkg::ST_OKV_BAD;
					end else if (v_done) begin
						ok_d    = (acc_next != 64'd0);
						phase_d = pbs_pkg::PH_KEY;
					end
				end
				pbs_pkg::PH_SKIPVAR: begin
					if (v_long) begin
						err_d = pbs_pkg::ST_KEY_BAD;
					end else if (v_done) begin
						phase_d = pbs_pkg::PH_KEY;
					end
				end
				pbs_pkg::PH_LEN: begin
					if (v_long) begin
						err_d = pbs_pkg::ST_LEN_BAD;
					end else if (v_done) begin
						rem_d  = acc_next;
						plen_d = '0;
						if (acc_next == 64'd0) begin
							if (action_q == pbs_pkg::ACT_TEXT) begin
								bank_d = !bank_q;
								clen_d = '0;
							end
							action_d = pbs_pkg::ACT_NONE;
							phase_d  = pbs_pkg::PH_KEY;
						end else begin
							phase_d = pbs_pkg::PH_BODY;
						end
					end
				end
				pbs_pkg::PH_BODY: begin
					if (action_q == pbs_pkg::ACT_TEXT && plen_q < TEXT_MAX) begin
						wr_en  = 1'b1;
						plen_d = plen_inc;
					end
					rem_d = rem_dec;
					if (rem_dec == 64'd0) begin
						if (action_q == pbs_pkg::ACT_TEXT) begin
							bank_d = !bank_q;
							clen_d = plen_d;
							plen_d = '0;
						end
						action_d = pbs_pkg::ACT_NONE;
						phase_d  = pbs_pkg::PH_KEY;
					end
				end
				pbs_pkg::PH_FIX: begin
					rem_d = rem_dec;
					if (rem_dec == 64'd0) begin
						action_d = pbs_pkg::ACT_NONE;
						phase_d  = pbs_pkg::PH_KEY;
					end
				end
				default: begin
					phase_d = pbs_pkg::PH_KEY;
				end
			endcase
		end
	end

	always_comb begin
		if (err_q != pbs_pkg::ST_OK) begin
			end_st = err_q;
		end else begin
			case (phase_q)
				pbs_pkg::PH_KEY:     end_st = (cnt_q != 4'd0) ? pbs_pkg::ST_KEY_BAD : pbs_pkg::ST_OK;
				pbs_pkg::PH_OKVAL:   end_st = pbs_pkg::ST_OKV_BAD;
				pbs_pkg::PH_SKIPVAR: end_st = pbs_pkg::ST_KEY_BAD;
				pbs_pkg::PH_LEN:     end_st = pbs_pkg::ST_LEN_BAD;
				pbs_pkg::PH_BODY:    end_st = pbs_pkg::ST_LEN_PAST;
				pbs_pkg::PH_FIX: begin
					end_st = (action_q == pbs_pkg::ACT_F32) ? pbs_pkg::ST_F32_BAD
					                                        : pbs_pkg::ST_OKV_BAD;
				end
				default:             end_st = pbs_pkg::ST_OK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= pbs_pkg::PH_KEY;
			action_q <= pbs_pkg::ACT_NONE;
			accum_q  <= '0;
			cnt_q    <= '0;
			rem_q    <= '0;
			ok_q     <= 1'b0;
			err_q    <= pbs_pkg::ST_OK;
			bank_q   <= 1'b0;
			clen_q   <= '0;
			plen_q   <= '0;
			tk_q     <= '0;
		end else if (cmd.clear) begin
			phase_q  <= pbs_pkg::PH_KEY;
			action_q <= pbs_pkg::ACT_NONE;
			accum_q  <= '0;
			cnt_q    <= '0;
			rem_q    <= '0;
			ok_q     <= 1'b0;
			err_q    <= pbs_pkg::ST_OK;
			clen_q   <= '0;
			plen_q   <= '0;
			tk_q     <= '0;
		end else begin
			phase_q  <= phase_d;
			action_q <= action_d;
			accum_q  <= accum_d;
			cnt_q    <= cnt_d;
			rem_q    <= rem_d;
			ok_q     <= ok_d;
			err_q    <= err_d;
			bank_q   <= bank_d;
			clen_q   <= clen_d;
			plen_q   <= plen_d;
			if (cmd.load_text) begin
				tk_q <= tk_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{!bank_q, plen_q[IDX_W-1:0]}] <= data_byte;
		end
		rdata_q <= mem[{bank_q, rd_idx[IDX_W-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.load_sum || cmd.load_text) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sum) begin
			kind         <= 1'b0;
			status       <= end_st;
			ok_flag      <= ok_q;
			error_length <= clen_q;
			error_char   <= 8'd0;
			last_result  <= (clen_q == '0);
		end else if (cmd.load_text) begin
			kind        <= 1'b1;
			error_char  <= rdata_q;
			last_result <= sts.text_last;
		end
	end

	assign sts.len_zero  = (clen_q == '0);
	assign sts.text_last = (tk_inc == clen_q);
	assign sts.out_free  = !res_valid || !res_stall;

endmodule
`default_nettype wire

// ===== rtl/protobuf_status_message_parser.sv =====
// Top level: protobuf status message parser, controller plus datapath.
//
// channel  dir  handshake            payload
// message  in   msg_valid/msg_stall  data_byte, is_last, no_byte
// result   out  res_valid/res_stall  kind, status, ok_flag, error_length, error_char, last_result
//
// One message byte is taken per cycle while parsing.
// After a last request, the summary and then N text bytes leave the output register at
// one per cycle while res_stall is low; the text store read port sets that pace, and
// msg_stall is high meanwhile.
// Result stall holds the output register and lengthens msg_stall only after a last request.
// Reset clears all parse state; the text store holds no reset value.
`default_nettype none
module protobuf_status_message_parser #(
	parameter int ERR_CAP = 64
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        msg_valid,
	output logic                       msg_stall,
	input  wire  [7:0]                 data_byte,
	input  wire                        is_last,
	input  wire                        no_byte,
	output logic                       res_valid,
	input  wire                        res_stall,
	output logic                       kind,
	output logic [2:0]                 status,
	output logic                       ok_flag,
	output logic [pbs_pkg::LEN_W-1:0]  error_length,
	output logic [7:0]                 error_char,
	output logic                       last_result
);

	pbs_pkg::cmd_t cmd;
	pbs_pkg::sts_t sts;

	pbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.is_last   (is_last),
		.no_byte   (no_byte),
		.sts       (sts),
		.cmd       (cmd)
	);

	pbs_dp #(
		.ERR_CAP (ERR_CAP)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.data_byte    (data_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.status       (status),
		.ok_flag      (ok_flag),
		.error_length (error_length),
		.error_char   (error_char),
		.last_result  (last_result)
	);

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_stall && is_last |=> msg_stall)
		else $error("message input open after last request");

	a_text_has_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_text |-> !sts.len_zero)
		else $error("text byte emitted with zero committed length");

	a_text_len_nz: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind |-> error_length != '0)
		else $error("text result with zero error length");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_sum || cmd.load_text |-> !cmd.take && sts.out_free)
		else $error("result load while parsing or output busy");

endmodule
`default_nettype wire
